// ----- rtl/iprt_pkg.sv -----
package iprt_pkg;

	// default table depth, used by the top level
	localparam int ENTRIES_DEF = 16;

	// widths fixed by the word formats
	localparam int ADDR_W   = 32;
	localparam int IFACE_W  = 8;
	localparam int HIDX_W   = 4;
	localparam int SLOT_W   = 8;
	localparam int STAT_W   = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// register map (word index)
	localparam logic [0:0] REG_TABLE_ENABLE = 1'b0;

	// command codes
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_UNREACH = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOSUP   = 2'd3
	} status_t;

	// one stored route
	typedef struct packed {
		logic [ADDR_W-1:0]  network;
		logic [ADDR_W-1:0]  mask;
		logic [ADDR_W-1:0]  gateway;
		logic [IFACE_W-1:0] iface;
		logic               dflt;
	} entry_t;

	// write request broadcast to the cells
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		entry_t            ent;
	} wr_t;

	// search token that walks down the chain
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] dest;
		logic              hit;
		logic [HIDX_W-1:0] hit_idx;
		entry_t            hit_ent;
		logic              dfl;
		logic [HIDX_W-1:0] dfl_idx;
		entry_t            dfl_ent;
	} token_t;

	// one result word
	typedef struct packed {
		status_t           status;
		logic [HIDX_W-1:0] hit_index;
		entry_t            ent;
	} result_t;

endpackage

// ----- rtl/iprt_if.sv -----
// request channel: commands into the table
interface iprt_req_if;
	import iprt_pkg::*;

	logic               valid;
	logic               ready;
	logic               command;
	logic [ADDR_W-1:0]  dest_address;
	logic [ADDR_W-1:0]  route_network;
	logic [ADDR_W-1:0]  route_mask;
	logic [ADDR_W-1:0]  route_gateway;
	logic [IFACE_W-1:0] iface_id;
	logic               is_default;

	modport source (
		output valid, command, dest_address, route_network, route_mask,
			route_gateway, iface_id, is_default,
		input  ready
	);
	modport sink (
		input  valid, command, dest_address, route_network, route_mask,
			route_gateway, iface_id, is_default,
		output ready
	);
endinterface

// response channel: one result word per command
interface iprt_rsp_if;
	import iprt_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [HIDX_W-1:0]  hit_index;
	logic [ADDR_W-1:0]  out_network;
	logic [ADDR_W-1:0]  out_mask;
	logic [ADDR_W-1:0]  out_gateway;
	logic [IFACE_W-1:0] out_iface;
	logic               out_default;

	modport source (
		output valid, status, hit_index, out_network, out_mask, out_gateway,
			out_iface, out_default,
		input  ready
	);
	modport sink (
		input  valid, status, hit_index, out_network, out_mask, out_gateway,
			out_iface, out_default,
		output ready
	);
endinterface

// ----- rtl/ipv4_route_table_lookup_top.sv -----
// channel | dir | handshake     | word
// req     | in  | valid/ready   | command, dest_address, route fields
// rsp     | out | valid/ready   | status, hit_index, out_ fields
// apb     | in  | psel/penable  | table_enable at word 0
//
// An add or a disabled-table command answers in the cycle after it is taken.
// A lookup walks one cell per cycle while rsp is not stalled, through every cell register
// and then the output register; the next word is taken only after its result is registered.
// Reset clears the route count and sets table_enable; routes are not cleared.
// A stalled rsp holds the token in the last cell; req waits while busy.
module ipv4_route_table_lookup_top #(
	parameter int ENTRIES = iprt_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	iprt_req_if.sink                      req,
	iprt_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iprt_pkg::PADDR_W-1:0]  paddr,
	input  logic [iprt_pkg::PDATA_W-1:0]  pwdata,
	output logic [iprt_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import iprt_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	logic          enable_q;
	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          rsp_valid_q;
	result_t       rsp_q;

	token_t        tok [ENTRIES+1];
	wr_t           wr;
	logic          out_free;
	logic          adv;
	logic          fire;
	logic          full;
	logic          done;
	result_t       imm_res;
	result_t       lkp_res;
	entry_t        req_ent;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == REG_TABLE_ENABLE) ? PDATA_W'(enable_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2:2] == REG_TABLE_ENABLE) begin
			enable_q <= pwdata[0];
		end
	end

	// handshake control
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign done      = tok[ENTRIES].valid && out_free;
	assign adv       = !(tok[ENTRIES].valid && !out_free);
	assign req.ready = !busy_q && out_free;
	assign fire      = req.valid && req.ready;
	assign full      = count_q == CW'(ENTRIES);

	assign req_ent.network = req.route_network;
	assign req_ent.mask    = req.route_mask;
	assign req_ent.gateway = req.route_gateway;
	assign req_ent.iface   = req.iface_id;
	assign req_ent.dflt    = req.is_default;

	// append route at the next free slot
	assign wr.en   = fire && enable_q && req.command == CMD_ADD && !full;
	assign wr.slot = SLOT_W'(count_q);
	assign wr.ent  = req_ent;

	// inject a search token into the head of the chain
	always_comb begin
		tok[0]       = '0;
		tok[0].valid = fire && enable_q && req.command == CMD_LOOKUP;
		tok[0].dest  = req.dest_address;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		iprt_cell #(
			.ENTRIES (ENTRIES),
			.IDX     (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.count   (count_q),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	// answer for add and disabled commands
	always_comb begin
		imm_res = '0;
		if (!enable_q) begin
			imm_res.status = ST_NOSUP;
		end else if (full) begin
			imm_res.status = ST_FULL;
		end else begin
			imm_res.status    = ST_OK;
			imm_res.hit_index = HIDX_W'(count_q);
			imm_res.ent       = req_ent;
		end
	end

	// answer from the token leaving the last cell
	always_comb begin
		lkp_res = '0;
		if (tok[ENTRIES].hit) begin
			lkp_res.status    = ST_OK;
			lkp_res.hit_index = tok[ENTRIES].hit_idx;
			lkp_res.ent       = tok[ENTRIES].hit_ent;
		end else if (tok[ENTRIES].dfl) begin
			lkp_res.status    = ST_OK;
			lkp_res.hit_index = tok[ENTRIES].dfl_idx;
			lkp_res.ent       = tok[ENTRIES].dfl_ent;
		end else begin
			lkp_res.status = ST_UNREACH;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				count_q <= count_q + 1'b1;
			end
			if (tok[0].valid) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if ((fire && !tok[0].valid) || done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire && !tok[0].valid) begin
			rsp_q <= imm_res;
		end else if (done) begin
			rsp_q <= lkp_res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.hit_index   = rsp_q.hit_index;
	assign rsp.out_network = rsp_q.ent.network;
	assign rsp.out_mask    = rsp_q.ent.mask;
	assign rsp.out_gateway = rsp_q.ent.gateway;
	assign rsp.out_iface   = rsp_q.ent.iface;
	assign rsp.out_default = rsp_q.ent.dflt;

endmodule

// ----- rtl/iprt_cell.sv -----
module iprt_cell #(
	parameter int ENTRIES = 16,
	parameter int IDX     = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [$clog2(ENTRIES+1)-1:0]    count,
	input  iprt_pkg::wr_t                   wr,
	input  iprt_pkg::token_t                tok_in,
	output iprt_pkg::token_t                tok_out
);
	import iprt_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	entry_t entry_q;
	token_t tok_q;
	token_t tok_nxt;
	logic   active;
	logic   match;

	// route slot owned by this cell
	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == SLOT_W'(IDX)) begin
			entry_q <= wr.ent;
		end
	end

	assign active = count > CW'(IDX);
	assign match  = (tok_in.dest & entry_q.mask) == (entry_q.network & entry_q.mask);

	// first prefix hit and first default route win
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && active) begin
			if (!tok_in.hit && match) begin
				tok_nxt.hit     = 1'b1;
				tok_nxt.hit_idx = HIDX_W'(IDX);
				tok_nxt.hit_ent = entry_q;
			end
			if (!tok_in.dfl && entry_q.dflt) begin
				tok_nxt.dfl     = 1'b1;
				tok_nxt.dfl_idx = HIDX_W'(IDX);
				tok_nxt.dfl_ent = entry_q;
			end
		end
	end

	// token hop to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- rtl/iprt_chk.sv -----
module iprt_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [iprt_pkg::STAT_W-1:0]   status,
	input logic [iprt_pkg::HIDX_W-1:0]   hit_index,
	input logic [iprt_pkg::ADDR_W-1:0]   out_network,
	input logic [iprt_pkg::ADDR_W-1:0]   out_mask,
	input logic [iprt_pkg::ADDR_W-1:0]   out_gateway,
	input logic [iprt_pkg::IFACE_W-1:0]  out_iface,
	input logic                          out_default
);
	import iprt_pkg::*;

	logic empty_word;

	assign empty_word = hit_index == '0 && out_network == '0 && out_mask == '0
		&& out_gateway == '0 && out_iface == '0 && !out_default;

	// a stalled result word stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp word dropped while stalled");

	// error results carry no entry
	a_nosup_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_NOSUP |-> empty_word)
		else $error("not-supported result carries entry data");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> empty_word)
		else $error("table-full result carries entry data");

	a_unreach_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_UNREACH |-> empty_word)
		else $error("unreachable result carries entry data");

endmodule

bind ipv4_route_table_lookup_top iprt_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.hit_index   (rsp.hit_index),
	.out_network (rsp.out_network),
	.out_mask    (rsp.out_mask),
	.out_gateway (rsp.out_gateway),
	.out_iface   (rsp.out_iface),
	.out_default (rsp.out_default)
);

// ----- verif/ipv4_route_table_lookup_top_test.sv -----
`timescale 1ns / 100ps

module ipv4_route_table_lookup_top_test;
	import iprt_pkg::*;

	localparam int DEPTH       = ENTRIES_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_WORDS = 1420;
	localparam logic [PADDR_W-1:0] ENABLE_ADDR   = PADDR_W'(4 * REG_TABLE_ENABLE);
	localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);

	// one command word as the sender sees it
	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] dest;
		entry_t            route;
	} cmd_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	iprt_req_if req_ch ();
	iprt_rsp_if rsp_ch ();

	ipv4_route_table_lookup_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the route table and its enable
	entry_t routes [DEPTH];
	int     route_cnt;
	logic   tbl_on;

	result_t answers_due [$];
	result_t want, got;

	int  fault_cnt;
	int  stall_cycles;
	int  adds_sent, lookups_sent, words_checked;
	int  status_seen [4];
	bit  no_idle;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// expected answer for one accepted word; updates the shadow table
	function automatic result_t route_answer(input cmd_word_t w);
		result_t r;
		int      slot;
		r = '0;
		slot = -1;
		if (!tbl_on) begin
			r.status = ST_NOSUP;
			return r;
		end
		if (w.cmd == CMD_ADD) begin
			if (route_cnt >= DEPTH) begin
				r.status = ST_FULL;
				return r;
			end
			routes[route_cnt] = w.route;
			slot = route_cnt;
			route_cnt++;
		end else begin
			// first match in insertion order, then first default
			for (int i = 0; i < route_cnt && slot < 0; i++)
				if ((w.dest & routes[i].mask) == (routes[i].network & routes[i].mask))
					slot = i;
			for (int i = 0; i < route_cnt && slot < 0; i++)
				if (routes[i].dflt)
					slot = i;
			if (slot < 0) begin
				r.status = ST_UNREACH;
				return r;
			end
		end
		r.status = ST_OK;
		r.hit_index = HIDX_W'(slot);
		r.ent = routes[slot];
		return r;
	endfunction

	task automatic note_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("%s", msg);
	endtask

	function automatic bit idle_roll();
		return !no_idle && ($urandom_range(99) < 18);
	endfunction

	// send one command word and record its expected answer on acceptance
	task automatic send_word(input cmd_word_t w);
		@(negedge clk);
		while (idle_roll()) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid         = 1'b1;
		req_ch.command       = w.cmd;
		req_ch.dest_address  = w.dest;
		req_ch.route_network = w.route.network;
		req_ch.route_mask    = w.route.mask;
		req_ch.route_gateway = w.route.gateway;
		req_ch.iface_id      = w.route.iface;
		req_ch.is_default    = w.route.dflt;
		do @(posedge clk); while (!req_ch.ready);
		if (w.cmd == CMD_ADD)
			adds_sent++;
		else
			lookups_sent++;
		answers_due.push_back(route_answer(w));
	endtask

	function automatic cmd_word_t add_word(input logic [ADDR_W-1:0] net,
			input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] gw,
			input logic [IFACE_W-1:0] ifc, input logic dflt);
		cmd_word_t w;
		w.cmd = CMD_ADD;
		w.dest = $urandom;
		w.route.network = net;
		w.route.mask = mask;
		w.route.gateway = gw;
		w.route.iface = ifc;
		w.route.dflt = dflt;
		return w;
	endfunction

	function automatic cmd_word_t lookup_word(input logic [ADDR_W-1:0] dest);
		cmd_word_t w;
		w = add_word($urandom, $urandom, $urandom, IFACE_W'($urandom), 1'($urandom));
		w.cmd = CMD_LOOKUP;
		w.dest = dest;
		return w;
	endfunction

	// drop valid and hold off until every answer is back
	task automatic wait_answers_in();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[PADDR_W-1:2] == REG_TABLE_ENABLE)
			tbl_on = data[0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_enable_readback();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ENABLE_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(tbl_on))
			note_fault($sformatf("table_enable readback: expected %0d, got %h", tbl_on, prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// response side: random back-pressure
	always @(negedge clk)
		rsp_ch.ready = no_idle || ($urandom_range(99) >= 18);

	// compare each answer word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status      = status_t'(rsp_ch.status);
			got.hit_index   = rsp_ch.hit_index;
			got.ent.network = rsp_ch.out_network;
			got.ent.mask    = rsp_ch.out_mask;
			got.ent.gateway = rsp_ch.out_gateway;
			got.ent.iface   = rsp_ch.out_iface;
			got.ent.dflt    = rsp_ch.out_default;
			if (answers_due.size() == 0) begin
				note_fault($sformatf("unexpected answer word: status %0d idx %0d",
					got.status, got.hit_index));
			end else begin
				want = answers_due.pop_front();
				words_checked++;
				status_seen[want.status]++;
				if (got.status !== want.status || got.hit_index !== want.hit_index ||
						got.ent.network !== want.ent.network ||
						got.ent.mask !== want.ent.mask ||
						got.ent.gateway !== want.ent.gateway ||
						got.ent.iface !== want.ent.iface ||
						got.ent.dflt !== want.ent.dflt)
					note_fault($sformatf({"answer %0d mismatch: exp st %0d idx %0d net %h ",
						"mask %h gw %h if %h dflt %b / got st %0d idx %0d net %h mask %h ",
						"gw %h if %h dflt %b"}, words_checked,
						want.status, want.hit_index, want.ent.network, want.ent.mask,
						want.ent.gateway, want.ent.iface, want.ent.dflt,
						got.status, got.hit_index, got.ent.network, got.ent.mask,
						got.ent.gateway, got.ent.iface, got.ent.dflt));
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("ipv4_route_table_lookup_top_test: done, errors");
			$finish;
		end
	end

	// lookups with nothing stored
	task automatic test_empty_table();
		send_word(lookup_word(32'h0000_0000));
		send_word(lookup_word(32'hFFFF_FFFF));
	endtask

	// disabled table answers not supported to adds and lookups
	task automatic test_disabled_table();
		wait_answers_in();
		apb_write(ENABLE_ADDR, '0);
		check_enable_readback();
		send_word(add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
		send_word(lookup_word(32'hFFFF_FFFF));
		wait_answers_in();
		// write past the register list is dropped
		apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
		check_enable_readback();
		send_word(lookup_word(32'h0000_0000));
		wait_answers_in();
		apb_write(ENABLE_ADDR, 32'hFFFF_FFFF);
		check_enable_readback();
	endtask

	// hand-built routes: exact host, default fallback, first match wins
	task automatic test_directed_routes();
		send_word(add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0));
		send_word(lookup_word(32'hFFFF_FFFF));
		send_word(lookup_word(32'h0000_0000));
		send_word(add_word(32'hC0A8_0100, 32'hFFFF_FF00, 32'h0000_0000, 8'h00, 1'b1));
		send_word(lookup_word(32'h0102_0304));
		send_word(lookup_word(32'hC0A8_01FE));
		send_word(add_word(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'h5A, 1'b1));
		send_word(lookup_word(32'h0A12_3456));
		send_word(lookup_word(32'h0B00_0000));
		// narrower route added later never beats an earlier match
		send_word(add_word(32'h0A12_FFFF, 32'hFFFF_0000, 32'h0A12_0001, 8'hA5, 1'b0));
		send_word(lookup_word(32'h0A12_0001));
		send_word(lookup_word(32'h8000_0000));
	endtask

	// mostly well-formed adds and lookups aimed at stored routes
	task automatic test_random_traffic();
		cmd_word_t w;
		int        roll, k, pfx;
		logic [ADDR_W-1:0] mask;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 300)
				no_idle = 1'b1;
			if (n == 550)
				no_idle = 1'b0;
			if (n == 700 || n == 1150) begin
				wait_answers_in();
				apb_write(ENABLE_ADDR, '0);
			end
			if (n == 720 || n == 1160) begin
				wait_answers_in();
				apb_write(ENABLE_ADDR, 32'h0000_0001);
				check_enable_readback();
			end
			roll = $urandom_range(99);
			if (route_cnt < DEPTH && roll < 2) begin
				pfx = $urandom_range(32, 1);
				mask = 32'hFFFF_FFFF << (32 - pfx);
				if ($urandom_range(99) < 15)
					mask = $urandom;
				if (route_cnt == DEPTH - 1 && $urandom_range(1))
					mask = '0;
				w = add_word($urandom, mask, $urandom, IFACE_W'($urandom),
					$urandom_range(99) < 30);
			end else if (route_cnt >= DEPTH && roll < 10) begin
				// add against a full table, arbitrary content
				w = add_word($urandom, $urandom, $urandom, IFACE_W'($urandom),
					1'($urandom));
			end else if (route_cnt > 0 && roll < 75) begin
				k = $urandom_range(route_cnt - 1);
				w = lookup_word((routes[k].network & routes[k].mask) |
					(ADDR_W'($urandom) & ~routes[k].mask));
			end else if (roll < 85) begin
				w = lookup_word($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000);
			end else begin
				w = lookup_word($urandom);
			end
			send_word(w);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ADD;
		req_ch.dest_address = '0;
		req_ch.route_network = '0;
		req_ch.route_mask = '0;
		req_ch.route_gateway = '0;
		req_ch.iface_id = '0;
		req_ch.is_default = 1'b0;
		rsp_ch.ready = 1'b1;
		route_cnt = 0;
		tbl_on = 1'b1;
		fault_cnt = 0;
		stall_cycles = 0;
		no_idle = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		check_enable_readback();
		test_empty_table();
		test_disabled_table();
		test_directed_routes();
		test_random_traffic();
		wait_answers_in();

		$display("ran %0d adds and %0d lookups, %0d answers checked, %0d routes stored",
			adds_sent, lookups_sent, words_checked, route_cnt);
		$display("answers: ok %0d, unreachable %0d, full %0d, not supported %0d",
			status_seen[ST_OK], status_seen[ST_UNREACH], status_seen[ST_FULL],
			status_seen[ST_NOSUP]);
		if (fault_cnt == 0 && answers_due.size() == 0) begin
			$display("ipv4_route_table_lookup_top_test: done, clean");
		end else begin
			$display("%0d faults", fault_cnt);
			$display("ipv4_route_table_lookup_top_test: done, errors");
		end
		$finish;
	end

endmodule
